// File: design/pmdd_pkg.sv
// pmdd_pkg: shared types, register map and constants of the PID motor drive block
// used by every module in the design folder; depends on nothing

package pmdd_pkg;

   // default parameter values
   localparam int DEF_SAMPLE_WIDTH = 16;
   localparam int DEF_FRAC_BITS    = 8;

   // fixed field widths
   localparam int GAIN_W     = 16;
   localparam int ILIM_W     = 15;
   localparam int OLIM_W     = 16;
   localparam int MAG_W      = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [GAIN_W-1:0] RST_GAIN           = '0;
   localparam logic [ILIM_W-1:0] RST_INTEGRAL_LIMIT = 15'd2000;
   localparam logic [OLIM_W-1:0] RST_OUTPUT_LIMIT   = 16'd59999;
   localparam logic [OLIM_W-1:0] RST_DEADBAND_DRIVE = 16'd5000;
   localparam logic [OLIM_W-1:0] RST_DEADBAND_TURN  = 16'd9000;

   // register indexes (byte address is 4 * index)
   typedef enum logic [2:0] {
      REG_GAIN_PROP      = 3'd0,
      REG_GAIN_INTEG     = 3'd1,
      REG_GAIN_DERIV     = 3'd2,
      REG_INTEGRAL_LIMIT = 3'd3,
      REG_OUTPUT_LIMIT   = 3'd4,
      REG_DEADBAND_DRIVE = 3'd5,
      REG_DEADBAND_TURN  = 3'd6
   } reg_index_type;

   // configuration register file contents
   typedef struct packed {
      logic [GAIN_W-1:0] gain_prop;
      logic [GAIN_W-1:0] gain_integ;
      logic [GAIN_W-1:0] gain_deriv;
      logic [ILIM_W-1:0] integral_limit;
      logic [OLIM_W-1:0] output_limit;
      logic [OLIM_W-1:0] deadband_drive;
      logic [OLIM_W-1:0] deadband_turn;
   } cfg_type;

   // load strobes of the two multiply-add stages
   typedef struct packed {
      logic load_prod;
      logic load_acc;
   } mac_ctl_type;

   // error sum width: the sample width plus one bit, at least wide enough for the clamp
   function automatic int sum_width(input int sw);
      int w;
      w = sw + 1;
      if (w < ILIM_W + 1) w = ILIM_W + 1;
      return w;
   endfunction

   // width of the exact sum of the three gain products
   function automatic int acc_width(input int sw);
      int wi;
      int wd;
      wi = GAIN_W + sum_width(sw);
      wd = GAIN_W + sw + 2;
      return ((wi > wd) ? wi : wd) + 2;
   endfunction

endpackage

// File: design/pmdd_csr.sv
// pmdd_csr: APB-style configuration register file of the PID motor drive block
// depends on pmdd_pkg

module pmdd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pmdd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pmdd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pmdd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output pmdd_pkg::cfg_type                   cfg
);

   localparam int PAD16 = pmdd_pkg::CSR_DATA_W - 16;
   localparam int PAD15 = pmdd_pkg::CSR_DATA_W - pmdd_pkg::ILIM_W;

   pmdd_pkg::cfg_type       cfg_ff;
   pmdd_pkg::cfg_type       cfg_in;
   pmdd_pkg::reg_index_type reg_idx;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = pmdd_pkg::reg_index_type'(csr_paddr[pmdd_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            pmdd_pkg::REG_GAIN_PROP:      cfg_in.gain_prop      = csr_pwdata[15:0];
            pmdd_pkg::REG_GAIN_INTEG:     cfg_in.gain_integ     = csr_pwdata[15:0];
            pmdd_pkg::REG_GAIN_DERIV:     cfg_in.gain_deriv     = csr_pwdata[15:0];
            pmdd_pkg::REG_INTEGRAL_LIMIT:
               cfg_in.integral_limit = csr_pwdata[pmdd_pkg::ILIM_W-1:0];
            pmdd_pkg::REG_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_pwdata[15:0];
            pmdd_pkg::REG_DEADBAND_DRIVE: cfg_in.deadband_drive = csr_pwdata[15:0];
            pmdd_pkg::REG_DEADBAND_TURN:  cfg_in.deadband_turn  = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop      <= pmdd_pkg::RST_GAIN;
         cfg_ff.gain_integ     <= pmdd_pkg::RST_GAIN;
         cfg_ff.gain_deriv     <= pmdd_pkg::RST_GAIN;
         cfg_ff.integral_limit <= pmdd_pkg::RST_INTEGRAL_LIMIT;
         cfg_ff.output_limit   <= pmdd_pkg::RST_OUTPUT_LIMIT;
         cfg_ff.deadband_drive <= pmdd_pkg::RST_DEADBAND_DRIVE;
         cfg_ff.deadband_turn  <= pmdd_pkg::RST_DEADBAND_TURN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back mux
   always_comb begin
      unique case (reg_idx)
         pmdd_pkg::REG_GAIN_PROP:      csr_prdata = {{PAD16{1'b0}}, cfg_ff.gain_prop};
         pmdd_pkg::REG_GAIN_INTEG:     csr_prdata = {{PAD16{1'b0}}, cfg_ff.gain_integ};
         pmdd_pkg::REG_GAIN_DERIV:     csr_prdata = {{PAD16{1'b0}}, cfg_ff.gain_deriv};
         pmdd_pkg::REG_INTEGRAL_LIMIT: csr_prdata = {{PAD15{1'b0}}, cfg_ff.integral_limit};
         pmdd_pkg::REG_OUTPUT_LIMIT:   csr_prdata = {{PAD16{1'b0}}, cfg_ff.output_limit};
         pmdd_pkg::REG_DEADBAND_DRIVE: csr_prdata = {{PAD16{1'b0}}, cfg_ff.deadband_drive};
         pmdd_pkg::REG_DEADBAND_TURN:  csr_prdata = {{PAD16{1'b0}}, cfg_ff.deadband_turn};
         default:                      csr_prdata = '0;
      endcase
   end

endmodule

// File: design/pmdd_error.sv
// pmdd_error: error, clamped error sum and error difference stage
// holds the controller state; depends on pmdd_pkg

module pmdd_error #(
   parameter int SAMPLE_WIDTH = pmdd_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  logic signed [SAMPLE_WIDTH-1:0]           setpoint,
   input  logic signed [SAMPLE_WIDTH-1:0]           measured,
   input  logic [pmdd_pkg::ILIM_W-1:0]              integral_limit,
   output logic signed [SAMPLE_WIDTH:0]             err,
   output logic signed [pmdd_pkg::sum_width(SAMPLE_WIDTH)-1:0] err_sum,
   output logic signed [SAMPLE_WIDTH+1:0]           err_delta
);

   localparam int EW   = SAMPLE_WIDTH + 1;
   localparam int SUMW = pmdd_pkg::sum_width(SAMPLE_WIDTH);
   localparam int CW   = SUMW + 1;
   localparam int DW   = SAMPLE_WIDTH + 2;

   logic signed [EW-1:0]   err_ff;
   logic signed [EW-1:0]   err_in;
   logic signed [SUMW-1:0] sum_ff;
   logic signed [SUMW-1:0] sum_in;
   logic signed [DW-1:0]   delta_ff;
   logic signed [DW-1:0]   delta_in;
   logic signed [CW-1:0]   sum_raw;
   logic signed [CW-1:0]   sum_clamp;
   logic signed [CW-1:0]   lim_pos;
   logic signed [CW-1:0]   lim_neg;

   // error and its change since the previous transaction
   assign err_in   = $signed({setpoint[SAMPLE_WIDTH-1], setpoint})
                   - $signed({measured[SAMPLE_WIDTH-1], measured});
   assign delta_in = DW'(err_in) - DW'(err_ff);

   // running sum with symmetric clamp
   assign sum_raw = CW'(sum_ff) + CW'(err_in);
   assign lim_pos = $signed({{(CW-pmdd_pkg::ILIM_W){1'b0}}, integral_limit});
   assign lim_neg = -lim_pos;

   always_comb begin
      priority if (sum_raw > lim_pos) begin
         sum_clamp = lim_pos;
      end else if (sum_raw < lim_neg) begin
         sum_clamp = lim_neg;
      end else begin
         sum_clamp = sum_raw;
      end
   end

   assign sum_in = sum_clamp[SUMW-1:0];

   // controller state: last error and clamped sum
   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
         sum_ff <= '0;
      end else if (load) begin
         err_ff <= err_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         delta_ff <= delta_in;
      end
   end

   assign err       = err_ff;
   assign err_sum   = sum_ff;
   assign err_delta = delta_ff;

endmodule

// File: design/pmdd_mac.sv
// pmdd_mac: gain products stage and sum-and-shift stage
// depends on pmdd_pkg

module pmdd_mac #(
   parameter int SAMPLE_WIDTH = pmdd_pkg::DEF_SAMPLE_WIDTH,
   parameter int FRAC_BITS    = pmdd_pkg::DEF_FRAC_BITS
) (
   input  logic                                     clock,
   input  pmdd_pkg::mac_ctl_type                    ctl,
   input  logic [pmdd_pkg::GAIN_W-1:0]              gain_prop,
   input  logic [pmdd_pkg::GAIN_W-1:0]              gain_integ,
   input  logic [pmdd_pkg::GAIN_W-1:0]              gain_deriv,
   input  logic signed [SAMPLE_WIDTH:0]             err,
   input  logic signed [pmdd_pkg::sum_width(SAMPLE_WIDTH)-1:0] err_sum,
   input  logic signed [SAMPLE_WIDTH+1:0]           err_delta,
   output logic signed [pmdd_pkg::acc_width(SAMPLE_WIDTH)-1:0] acc
);

   localparam int GW   = pmdd_pkg::GAIN_W;
   localparam int PW_P = GW + SAMPLE_WIDTH + 1;
   localparam int PW_I = GW + pmdd_pkg::sum_width(SAMPLE_WIDTH);
   localparam int PW_D = GW + SAMPLE_WIDTH + 2;
   localparam int AW   = pmdd_pkg::acc_width(SAMPLE_WIDTH);

   logic signed [GW-1:0]   kp;
   logic signed [GW-1:0]   ki;
   logic signed [GW-1:0]   kd;
   logic signed [PW_P-1:0] prod_p_in;
   logic signed [PW_P-1:0] prod_p_ff;
   logic signed [PW_I-1:0] prod_i_in;
   logic signed [PW_I-1:0] prod_i_ff;
   logic signed [PW_D-1:0] prod_d_in;
   logic signed [PW_D-1:0] prod_d_ff;
   logic signed [AW-1:0]   sum_all;
   logic signed [AW-1:0]   acc_in;
   logic signed [AW-1:0]   acc_ff;

   assign kp = $signed(gain_prop);
   assign ki = $signed(gain_integ);
   assign kd = $signed(gain_deriv);

   // three full-width products, one multiplier each
   assign prod_p_in = kp * err;
   assign prod_i_in = ki * err_sum;
   assign prod_d_in = kd * err_delta;

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
   end

   // exact sum, then floor shift by the gain fraction bits
   assign sum_all = AW'(prod_p_ff) + AW'(prod_i_ff) + AW'(prod_d_ff);
   assign acc_in  = sum_all >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (ctl.load_acc) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// File: design/pmdd_shape.sv
// pmdd_shape: output saturation, deadband and sign/magnitude result register
// depends on pmdd_pkg

module pmdd_shape #(
   parameter int SAMPLE_WIDTH = pmdd_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     load,
   input  logic signed [pmdd_pkg::acc_width(SAMPLE_WIDTH)-1:0] acc,
   input  logic                                     turn_mode,
   input  logic [pmdd_pkg::OLIM_W-1:0]              output_limit,
   input  logic [pmdd_pkg::OLIM_W-1:0]              deadband_drive,
   input  logic [pmdd_pkg::OLIM_W-1:0]              deadband_turn,
   output logic [pmdd_pkg::MAG_W-1:0]               drive_magnitude,
   output logic                                     positive_dir
);

   localparam int AW = pmdd_pkg::acc_width(SAMPLE_WIDTH);
   localparam int MW = pmdd_pkg::MAG_W;

   logic signed [AW-1:0] lim_pos;
   logic signed [AW-1:0] lim_neg;
   logic signed [AW-1:0] acc_abs;
   logic [MW-1:0]        mag_sat;
   logic [MW-1:0]        deadband;
   logic [MW-1:0]        mag_in;
   logic [MW-1:0]        mag_ff;
   logic                 pos_in;
   logic                 pos_ff;

   assign lim_pos = $signed({{(AW-pmdd_pkg::OLIM_W){1'b0}}, output_limit});
   assign lim_neg = -lim_pos;
   assign acc_abs = acc[AW-1] ? -acc : acc;

   // saturate to the output limit
   always_comb begin
      priority if ((acc > lim_pos) || (acc < lim_neg)) begin
         mag_sat = output_limit;
      end else begin
         mag_sat = acc_abs[MW-1:0];
      end
   end

   // mode-selected deadband forces small outputs to zero
   assign deadband = turn_mode ? deadband_turn : deadband_drive;
   assign mag_in   = (mag_sat < deadband) ? '0 : mag_sat;
   assign pos_in   = ~acc[AW-1] & (mag_in != '0);

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff <= mag_in;
         pos_ff <= pos_in;
      end
   end

   assign drive_magnitude = mag_ff;
   assign positive_dir    = pos_ff;

endmodule

// File: design/pid_motor_drive_deadband_top.sv
// pid_motor_drive_deadband_top: PID controller with integral clamp, output saturation
// and deadband; depends on pmdd_pkg, pmdd_csr, pmdd_error, pmdd_mac, pmdd_shape
//
//   channel  direction  contents
//   req      in         tdata: setpoint, measured; tuser: turn_mode
//   rsp      out        tdata: drive_magnitude; tuser: positive_dir
//   csr      in/out     APB-style register port, 7 registers at 4*index
//
// One transaction is accepted per cycle while req_tready is high.
// Five register stages: input, error/sum update, products, sum-and-shift, result.
// Each stage holds when the one after it is full and not moving, so req_tready drops
// only when all five stages hold data behind a stalled rsp channel.
// Synchronous reset clears stage valid bits, error sum, previous error; resets CSRs.

module pid_motor_drive_deadband_top #(
   parameter int SAMPLE_WIDTH = pmdd_pkg::DEF_SAMPLE_WIDTH,
   parameter int FRAC_BITS    = pmdd_pkg::DEF_FRAC_BITS,
   localparam int REQ_DATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_DATA_W-1:0]            req_tdata,  // setpoint, measured (low bits up)
   input  logic                             req_tuser,  // turn_mode
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pmdd_pkg::MAG_W-1:0]       rsp_tdata,  // drive_magnitude
   output logic                             rsp_tuser,  // positive_dir
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pmdd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pmdd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pmdd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int SUMW = pmdd_pkg::sum_width(SAMPLE_WIDTH);
   localparam int AW   = pmdd_pkg::acc_width(SAMPLE_WIDTH);

   pmdd_pkg::cfg_type     cfg;
   pmdd_pkg::mac_ctl_type mac_ctl;

   logic signed [SW-1:0]   setpoint_ff;
   logic signed [SW-1:0]   measured_ff;
   logic                   mode_s1_ff;
   logic                   mode_s2_ff;
   logic                   mode_s3_ff;
   logic                   mode_s4_ff;
   logic                   v1_ff;
   logic                   v2_ff;
   logic                   v3_ff;
   logic                   v4_ff;
   logic                   v5_ff;
   logic                   rdy1;
   logic                   rdy2;
   logic                   rdy3;
   logic                   rdy4;
   logic                   rdy5;
   logic                   ld1;
   logic                   ld2;
   logic                   ld3;
   logic                   ld4;
   logic                   ld5;
   logic signed [SW:0]     err;
   logic signed [SUMW-1:0] err_sum;
   logic signed [SW+1:0]   err_delta;
   logic signed [AW-1:0]   acc;

   // stage flow control: a stage moves when it is empty or the next one moves
   assign rdy5 = ~v5_ff | rsp_tready;
   assign rdy4 = ~v4_ff | rdy5;
   assign rdy3 = ~v3_ff | rdy4;
   assign rdy2 = ~v2_ff | rdy3;
   assign rdy1 = ~v1_ff | rdy2;

   assign ld1 = req_tvalid & rdy1;
   assign ld2 = v1_ff & rdy2;
   assign ld3 = v2_ff & rdy3;
   assign ld4 = v3_ff & rdy4;
   assign ld5 = v4_ff & rdy5;

   assign mac_ctl.load_prod = ld3;
   assign mac_ctl.load_acc  = ld4;

   assign req_tready = rdy1;
   assign rsp_tvalid = v5_ff;

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // input register and mode pipeline
   always_ff @(posedge clock) begin
      if (ld1) begin
         setpoint_ff <= $signed(req_tdata[SW-1:0]);
         measured_ff <= $signed(req_tdata[2*SW-1:SW]);
         mode_s1_ff  <= req_tuser;
      end
      if (ld2) mode_s2_ff <= mode_s1_ff;
      if (ld3) mode_s3_ff <= mode_s2_ff;
      if (ld4) mode_s4_ff <= mode_s3_ff;
   end

   pmdd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pmdd_error #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_error (
      .clock          (clock),
      .reset          (reset),
      .load           (ld2),
      .setpoint       (setpoint_ff),
      .measured       (measured_ff),
      .integral_limit (cfg.integral_limit),
      .err            (err),
      .err_sum        (err_sum),
      .err_delta      (err_delta)
   );

   pmdd_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_mac (
      .clock      (clock),
      .ctl        (mac_ctl),
      .gain_prop  (cfg.gain_prop),
      .gain_integ (cfg.gain_integ),
      .gain_deriv (cfg.gain_deriv),
      .err        (err),
      .err_sum    (err_sum),
      .err_delta  (err_delta),
      .acc        (acc)
   );

   pmdd_shape #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_shape (
      .clock           (clock),
      .load            (ld5),
      .acc             (acc),
      .turn_mode       (mode_s4_ff),
      .output_limit    (cfg.output_limit),
      .deadband_drive  (cfg.deadband_drive),
      .deadband_turn   (cfg.deadband_turn),
      .drive_magnitude (rsp_tdata),
      .positive_dir    (rsp_tuser)
   );

`ifndef ASSERT_OFF
   // back pressure reaches the input only when every stage is occupied
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff))
      else $error("input stalled while a stage is empty");

   // controller state moves only with a transaction entering the error stage
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !ld2 |=> ($stable(err_sum) && $stable(err)))
      else $error("error state changed without a transaction");

   // a forward direction always comes with a nonzero magnitude
   a_dir_mag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata != '0))
      else $error("positive direction with zero magnitude");
`endif

endmodule

// File: tb/pid_motor_drive_deadband_top_test.sv
// pid_motor_drive_deadband_top_test: self-checking testbench for the PID motor drive block
// holds its own PID prediction, drives req and csr, checks every rsp transaction in order
// depends on pmdd_pkg and pid_motor_drive_deadband_top

`timescale 1ns / 100ps

module pid_motor_drive_deadband_top_test;

   localparam int SW          = pmdd_pkg::DEF_SAMPLE_WIDTH;
   localparam int FRAC        = pmdd_pkg::DEF_FRAC_BITS;
   localparam int MW          = pmdd_pkg::MAG_W;
   localparam int REQ_W       = ((2 * SW + 7) / 8) * 8;
   localparam int MISS_REPORT = 10;
   // register index past the end of the map, writes to it are dropped
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      logic [MW-1:0] magnitude;
      logic          positive;
   } drive_type;

   // receiver stall patterns
   typedef enum int {SINK_ALWAYS, SINK_HALF, SINK_SPARSE, SINK_MOSTLY} sink_mode_type;

   // tracks controller state and the queue of predicted drive outputs
   class drive_scoreboard;
      longint gain_p, gain_i, gain_d;
      longint integ_lim, out_lim, band_drive, band_turn;
      longint err_sum, last_err;
      drive_type expected_drive[$];
      int failures;

      function new();
         gain_p     = longint'($signed(pmdd_pkg::RST_GAIN));
         gain_i     = longint'($signed(pmdd_pkg::RST_GAIN));
         gain_d     = longint'($signed(pmdd_pkg::RST_GAIN));
         integ_lim  = longint'(pmdd_pkg::RST_INTEGRAL_LIMIT);
         out_lim    = longint'(pmdd_pkg::RST_OUTPUT_LIMIT);
         band_drive = longint'(pmdd_pkg::RST_DEADBAND_DRIVE);
         band_turn  = longint'(pmdd_pkg::RST_DEADBAND_TURN);
         err_sum    = 0;
         last_err   = 0;
         failures   = 0;
      endfunction

      function longint clamp_sym(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] value);
         case (idx)
            pmdd_pkg::REG_GAIN_PROP:
               gain_p = longint'($signed(value[pmdd_pkg::GAIN_W-1:0]));
            pmdd_pkg::REG_GAIN_INTEG:
               gain_i = longint'($signed(value[pmdd_pkg::GAIN_W-1:0]));
            pmdd_pkg::REG_GAIN_DERIV:
               gain_d = longint'($signed(value[pmdd_pkg::GAIN_W-1:0]));
            pmdd_pkg::REG_INTEGRAL_LIMIT:
               integ_lim = longint'(value[pmdd_pkg::ILIM_W-1:0]);
            pmdd_pkg::REG_OUTPUT_LIMIT:
               out_lim = longint'(value[pmdd_pkg::OLIM_W-1:0]);
            pmdd_pkg::REG_DEADBAND_DRIVE:
               band_drive = longint'(value[pmdd_pkg::OLIM_W-1:0]);
            pmdd_pkg::REG_DEADBAND_TURN:
               band_turn = longint'(value[pmdd_pkg::OLIM_W-1:0]);
            default: ;
         endcase
      endfunction

      // one accepted sample: update error sum and previous error, queue the drive output
      function void note_sample(logic signed [SW-1:0] setpoint, logic signed [SW-1:0] measured,
                                logic turn);
         longint err;
         longint acc;
         longint u;
         longint band;
         drive_type d;
         err = longint'(setpoint) - longint'(measured);
         err_sum = clamp_sym(err_sum + err, integ_lim);
         acc = gain_p * err + gain_i * err_sum + gain_d * (err - last_err);
         u = clamp_sym(acc >>> FRAC, out_lim);
         band = turn ? band_turn : band_drive;
         if (u < band && u > -band) u = 0;
         last_err = err;
         d.magnitude = MW'((u < 0) ? -u : u);
         d.positive = (u > 0);
         expected_drive.push_back(d);
      endfunction

      function void report(string what);
         failures++;
         if (failures <= MISS_REPORT) $display("%0t: %s", $realtime, what);
      endfunction

      function void check_drive(logic [MW-1:0] magnitude, logic positive);
         drive_type d;
         if (expected_drive.size() == 0) begin
            report($sformatf("unexpected rsp transaction mag=%0d dir=%b", magnitude, positive));
            return;
         end
         d = expected_drive.pop_front();
         if (magnitude !== d.magnitude || positive !== d.positive)
            report($sformatf("rsp mismatch: expected mag=%0d dir=%b, got mag=%0d dir=%b",
                             d.magnitude, d.positive, magnitude, positive));
      endfunction

      function int pending();
         return expected_drive.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [REQ_W-1:0]                req_tdata;   // setpoint, measured (low bits up)
   logic                            req_tuser;   // turn_mode
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [MW-1:0]                   rsp_tdata;   // drive_magnitude
   logic                            rsp_tuser;   // positive_dir
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [pmdd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [pmdd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [pmdd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   drive_scoreboard model = new();
   int  burst_left = 0;
   bit  long_hold_pending = 0;

   pid_motor_drive_deadband_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock generation
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   initial begin
      #2_000_000;
      $display("pid_motor_drive_deadband_top verification failed");
      $finish;
   end

   // setup and access phases of one register write, then psel and penable return low
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      model.set_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // offer one sample, in bursts with random gaps between them
   task automatic send_item(input logic signed [SW-1:0] setpoint,
                            input logic signed [SW-1:0] measured, input logic turn);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 12) : $urandom_range(0, 2);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {measured, setpoint};
      req_tuser  <= turn;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model.note_sample(setpoint, measured, turn);
      burst_left--;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (model.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         1: return 16'($urandom());
         default: return 16'($signed($urandom_range(0, 1024)) - 512);
      endcase
   endfunction

   function automatic logic [15:0] pick_bound(input logic [15:0] top);
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return top;
         2: return 16'($urandom_range(0, 3000));
         default: return 16'($urandom()) & top;
      endcase
   endfunction

   // random register setting, upper pwdata bits left random
   task automatic load_random_settings();
      logic [31:0] v;
      v = $urandom(); v[15:0] = pick_gain();
      write_reg(pmdd_pkg::REG_GAIN_PROP, v);
      v = $urandom(); v[15:0] = pick_gain();
      write_reg(pmdd_pkg::REG_GAIN_INTEG, v);
      v = $urandom(); v[15:0] = pick_gain();
      write_reg(pmdd_pkg::REG_GAIN_DERIV, v);
      v = $urandom(); v[14:0] = 15'(pick_bound(16'h7FFF));
      write_reg(pmdd_pkg::REG_INTEGRAL_LIMIT, v);
      v = $urandom(); v[15:0] = pick_bound(16'hFFFF);
      write_reg(pmdd_pkg::REG_OUTPUT_LIMIT, v);
      v = $urandom(); v[15:0] = pick_bound(16'hFFFF);
      write_reg(pmdd_pkg::REG_DEADBAND_DRIVE, v);
      v = $urandom(); v[15:0] = pick_bound(16'hFFFF);
      write_reg(pmdd_pkg::REG_DEADBAND_TURN, v);
   endtask

   task automatic write_all(input logic [15:0] gp, input logic [15:0] gi, input logic [15:0] gd,
                            input logic [15:0] ilim, input logic [15:0] olim,
                            input logic [15:0] dbd, input logic [15:0] dbt);
      write_reg(pmdd_pkg::REG_GAIN_PROP, {16'h0, gp});
      write_reg(pmdd_pkg::REG_GAIN_INTEG, {16'h0, gi});
      write_reg(pmdd_pkg::REG_GAIN_DERIV, {16'h0, gd});
      write_reg(pmdd_pkg::REG_INTEGRAL_LIMIT, {16'h0, ilim});
      write_reg(pmdd_pkg::REG_OUTPUT_LIMIT, {16'h0, olim});
      write_reg(pmdd_pkg::REG_DEADBAND_DRIVE, {16'h0, dbd});
      write_reg(pmdd_pkg::REG_DEADBAND_TURN, {16'h0, dbt});
   endtask

   // mix of full-range, near-equal and corner samples
   task automatic send_random_sample();
      int sp;
      int mv;
      int corner[4];
      logic signed [SW-1:0] r;
      corner = '{-32768, 32767, 0, -1};
      r = SW'($urandom());
      sp = int'(r);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            r = SW'($urandom());
            mv = int'(r);
         end
         4, 5, 6: mv = sp + $signed($urandom_range(0, 600)) - 300;
         7: begin
            sp = corner[$urandom_range(0, 3)];
            mv = corner[$urandom_range(0, 3)];
         end
         default: mv = sp + $signed($urandom_range(0, 8)) - 4;
      endcase
      if (mv > 32767) mv = 32767;
      if (mv < -32768) mv = -32768;
      send_item(sp[SW-1:0], mv[SW-1:0], 1'($urandom_range(0, 1)));
   endtask

   task automatic run_random_phase(input int items, input bit long_hold, input bit mid_pause);
      load_random_settings();
      if (long_hold) long_hold_pending = 1;
      for (int i = 0; i < items; i++) begin
         if (mid_pause && i == items / 2) begin
            stop_sending();
            wait_drained();
         end
         send_random_sample();
      end
      stop_sending();
      wait_drained();
   endtask

   // result side: check each rsp transaction, stall on a changing pattern
   initial begin : rsp_sink
      int mode_left;
      int hold_left;
      sink_mode_type mode;
      mode_left = 0;
      hold_left = 0;
      mode = SINK_ALWAYS;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) model.check_drive(rsp_tdata, rsp_tuser);
         if (long_hold_pending) begin
            hold_left = 150;
            long_hold_pending = 0;
         end
         if (mode_left == 0) begin
            mode = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 100);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               SINK_ALWAYS: rsp_tready <= 1'b1;
               SINK_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               SINK_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= ($urandom_range(0, 6) != 0);
            endcase
         end
      end
   end

   // main sequence
   initial begin : stimulus
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero gains give zero drive even at full-scale error
      send_item(16'sd0, 16'sd0, 1'b0);
      send_item(16'sd32767, -16'sd32768, 1'b1);
      send_item(-16'sd32768, 16'sd32767, 1'b0);
      stop_sending();
      wait_drained();

      // unity gains, wide limits, no drive deadband, narrow turn deadband
      write_all(16'h0100, 16'h0100, 16'h0100, 16'h7FFF, 16'hFFFF, 16'd0, 16'd1000);
      send_item(16'sd32767, -16'sd32768, 1'b0);
      send_item(-16'sd32768, 16'sd32767, 1'b0);
      send_item(16'sd100, 16'sd0, 1'b0);
      send_item(16'sd0, 16'sd100, 1'b1);
      send_item(16'sd5, 16'sd5, 1'b0);
      send_item(-16'sd1, 16'sd0, 1'b0);
      send_item(16'sd1, 16'sd0, 1'b1);
      stop_sending();
      wait_drained();

      // zero integral and output limits: every output is zero
      write_all(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'hFFFF, 16'd0);
      send_item(16'sd32767, -16'sd32768, 1'b0);
      send_item(-16'sd32768, 16'sd32767, 1'b1);
      send_item(16'sd1234, -16'sd4321, 1'b1);
      stop_sending();
      wait_drained();

      // most negative proportional and derivative gains, maximum drive deadband, no turn deadband, dropped write
      write_all(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'd0);
      write_reg(REG_UNMAPPED, 32'h0000_0001);
      send_item(16'sd32767, -16'sd32768, 1'b1);
      send_item(-16'sd32768, 16'sd32767, 1'b1);
      send_item(16'sd0, 16'sd0, 1'b0);
      send_item(16'sd1, -16'sd1, 1'b1);
      send_item(-16'sd32768, -16'sd32768, 1'b0);
      stop_sending();
      wait_drained();

      // tiny limits and deadbands
      write_all(16'h0080, 16'h0001, 16'hFF00, 16'd1, 16'd1, 16'd1, 16'd2);
      send_item(16'sd3, 16'sd0, 1'b0);
      send_item(-16'sd3, 16'sd0, 1'b1);
      send_item(16'sd0, 16'sd0, 1'b1);
      stop_sending();
      wait_drained();

      // random settings and samples, one long receiver hold, one drain mid-phase
      for (int p = 0; p < 8; p++) run_random_phase(50, p == 2, p == 4);

      // trailing window for stray results
      repeat (20) @(posedge clock);
      if (model.failures == 0 && model.pending() == 0) begin
         $display("pid_motor_drive_deadband_top verification clean");
      end else begin
         $display("pid_motor_drive_deadband_top verification failed");
      end
      $finish;
   end

endmodule
